// ===== rtl/wbps_pkg.sv =====
// Shared constants, register index codes and the aligned-signature struct
// of the wildcard byte pattern scanner. No dependencies.
package wbps_pkg;

   // window depth and byte counter width
   localparam int PATTERN_MAX = 32;
   localparam int COUNT_BITS  = 32;

   // signature bytes held by the four pattern registers
   localparam int SIG_BYTES   = 32;
   localparam int SIG_IDX_W   = $clog2(SIG_BYTES);
   localparam int SIG_LIMIT   = (PATTERN_MAX < SIG_BYTES) ? PATTERN_MAX : SIG_BYTES;
   localparam int LEN_W       = $clog2(SIG_LIMIT + 1);

   localparam int ADDR_W      = 64;
   localparam int PLEN_W      = 6;
   localparam int MASK_W      = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PATTERN_0 = 3'd0,
      CSR_PATTERN_1 = 3'd1,
      CSR_PATTERN_2 = 3'd2,
      CSR_PATTERN_3 = 3'd3,
      CSR_WILDCARD  = 3'd4,
      CSR_LENGTH    = 3'd5,
      CSR_BASE      = 3'd6
   } csr_index_type;

   // signature laid out by window age: entry a is compared against the
   // byte taken in a beats ago; care is clear for wildcards and unused ages
   typedef struct packed {
      logic [SIG_LIMIT-1:0][7:0] sig_by_age;
      logic [SIG_LIMIT-1:0]      care;
      logic [LEN_W-1:0]          length;
      logic [ADDR_W-1:0]         base_minus_len;
   } cfg_type;

endpackage

// ===== rtl/wbps_req_if.sv =====
// Input channel of the scanner: one memory byte per beat with region flags.
// No dependencies.
interface wbps_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] memory_byte;
   logic       start_scan;
   logic       last_byte;

   modport source (output valid, memory_byte, start_scan, last_byte, input ready);
   modport sink   (input valid, memory_byte, start_scan, last_byte, output ready);
endinterface

// ===== rtl/wbps_rsp_if.sv =====
// Result channel of the scanner: hit flag, match address and no-match flag.
// Depends on wbps_pkg.
interface wbps_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       match_hit;
   logic [wbps_pkg::ADDR_W-1:0] match_address;
   logic                       no_match;

   modport source (output valid, match_hit, match_address, no_match, input ready);
   modport sink   (input valid, match_hit, match_address, no_match, output ready);
endinterface

// ===== rtl/wbps_csr.sv =====
// Configuration registers of the scanner and the registered signature
// alignment by window age. Depends on wbps_pkg.
module wbps_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output wbps_pkg::cfg_type                 cfg
);

   logic [63:0]                   pattern_ff [4];
   logic [wbps_pkg::MASK_W-1:0]   wildcard_ff;
   logic [wbps_pkg::PLEN_W-1:0]   length_ff;
   logic [wbps_pkg::ADDR_W-1:0]   base_ff;
   wbps_pkg::cfg_type             cfg_ff;
   wbps_pkg::cfg_type             cfg_in;
   logic [7:0]                    sig_byte [wbps_pkg::SIG_BYTES];
   logic [wbps_pkg::LEN_W-1:0]    len_eff;

   // take register writes, drop unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < 4; r++) begin
            pattern_ff[r] <= '0;
         end
         wildcard_ff <= '0;
         length_ff   <= wbps_pkg::PLEN_W'(1);
         base_ff     <= '0;
      end else if (csr_we) begin
         unique case (wbps_pkg::csr_index_type'(csr_index))
            wbps_pkg::CSR_PATTERN_0: pattern_ff[0] <= csr_wdata;
            wbps_pkg::CSR_PATTERN_1: pattern_ff[1] <= csr_wdata;
            wbps_pkg::CSR_PATTERN_2: pattern_ff[2] <= csr_wdata;
            wbps_pkg::CSR_PATTERN_3: pattern_ff[3] <= csr_wdata;
            wbps_pkg::CSR_WILDCARD:  wildcard_ff   <= csr_wdata[wbps_pkg::MASK_W-1:0];
            wbps_pkg::CSR_LENGTH:    length_ff     <= csr_wdata[wbps_pkg::PLEN_W-1:0];
            wbps_pkg::CSR_BASE:      base_ff       <= csr_wdata[wbps_pkg::ADDR_W-1:0];
            default: ;
         endcase
      end
   end

   // split the pattern registers into signature bytes
   always_comb begin
      for (int i = 0; i < wbps_pkg::SIG_BYTES; i++) begin
         sig_byte[i] = pattern_ff[i / 8][(i % 8) * 8 +: 8];
      end
   end

   // clamp the length: zero acts as one, saturate at the window limit
   always_comb begin
      if (length_ff == '0) begin
         len_eff = wbps_pkg::LEN_W'(1);
      end else if (length_ff > wbps_pkg::PLEN_W'(wbps_pkg::SIG_LIMIT)) begin
         len_eff = wbps_pkg::LEN_W'(wbps_pkg::SIG_LIMIT);
      end else begin
         len_eff = wbps_pkg::LEN_W'(length_ff);
      end
   end

   // lay the signature out by age: age a holds signature byte len-1-a
   always_comb begin
      int                            pos;
      logic [wbps_pkg::SIG_IDX_W-1:0] idx;
      cfg_in = '0;
      for (int a = 0; a < wbps_pkg::SIG_LIMIT; a++) begin
         pos = int'(len_eff) - 1 - a;
         idx = wbps_pkg::SIG_IDX_W'(pos);
         if (pos >= 0) begin
            cfg_in.sig_by_age[a] = sig_byte[idx];
            cfg_in.care[a]       = !wildcard_ff[idx];
         end
      end
      cfg_in.length         = len_eff;
      cfg_in.base_minus_len = base_ff - wbps_pkg::ADDR_W'(len_eff);
   end

   always_ff @(posedge clock) begin
      cfg_ff <= cfg_in;
   end

   assign cfg = cfg_ff;

endmodule

// ===== rtl/wbps_match.sv =====
// Byte window, region byte count and first-match logic of the scanner, with
// an input register and a result register. Depends on wbps_pkg and the
// channel interfaces.
module wbps_match (
   input  logic              clock,
   input  logic              reset,
   input  wbps_pkg::cfg_type cfg,
   wbps_req_if.sink          req,
   wbps_rsp_if.source        rsp
);

   localparam logic [wbps_pkg::COUNT_BITS-1:0] CountMax = '1;

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_start_ff;
   logic       in_last_ff;

   // scan state
   logic [7:0]                     window_ff [wbps_pkg::PATTERN_MAX];
   logic [wbps_pkg::COUNT_BITS-1:0] count_ff;
   logic                           found_ff;

   // result register
   logic                        out_valid_ff;
   logic                        hit_ff;
   logic [wbps_pkg::ADDR_W-1:0] addr_ff;
   logic                        no_match_ff;

   logic                           advance;
   logic [7:0]                     window_in [wbps_pkg::PATTERN_MAX];
   logic [wbps_pkg::COUNT_BITS-1:0] count_in;
   logic                           found_base;
   logic                           window_ok;
   logic                           hit_in;
   logic [wbps_pkg::ADDR_W-1:0]    addr_in;
   logic                           no_match_in;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;

   // hold the accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req.ready) begin
         in_valid_ff <= req.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req.ready && req.valid) begin
         in_byte_ff  <= req.memory_byte;
         in_start_ff <= req.start_scan;
         in_last_ff  <= req.last_byte;
      end
   end

   // shift the new byte into the window
   always_comb begin
      window_in[0] = in_byte_ff;
      for (int k = 1; k < wbps_pkg::PATTERN_MAX; k++) begin
         window_in[k] = window_ff[k - 1];
      end
   end

   // compare every age against the aligned signature
   always_comb begin
      window_ok = 1'b1;
      for (int a = 0; a < wbps_pkg::SIG_LIMIT; a++) begin
         if (cfg.care[a] && (window_in[a] != cfg.sig_by_age[a])) begin
            window_ok = 1'b0;
         end
      end
   end

   // count bytes of the region, saturating; start restarts the region
   always_comb begin
      if (in_start_ff) begin
         count_in = wbps_pkg::COUNT_BITS'(1);
      end else if (count_ff == CountMax) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + wbps_pkg::COUNT_BITS'(1);
      end
      found_base  = found_ff && !in_start_ff;
      hit_in      = !found_base && window_ok
                    && (count_in >= wbps_pkg::COUNT_BITS'(cfg.length));
      addr_in     = hit_in ? cfg.base_minus_len + wbps_pkg::ADDR_W'(count_in) : '0;
      no_match_in = in_last_ff && !found_base && !hit_in;
   end

   // advance scan state when the beat moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else if (advance && in_valid_ff) begin
         count_ff <= count_in;
         found_ff <= found_base || hit_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         window_ff <= window_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid_ff) begin
         hit_ff      <= hit_in;
         addr_ff     <= addr_in;
         no_match_ff <= no_match_in;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.match_hit     = hit_ff;
   assign rsp.match_address = addr_ff;
   assign rsp.no_match      = no_match_ff;

endmodule

// ===== rtl/wildcard_byte_pattern_scan.sv =====
// A byte beat accepted into the input register goes on through the result register.
// Throughput: one byte per cycle; when the result beat is not taken the result register
// stalls, as does a full input register, and req.ready then follows rsp.ready.
// Reset clears the configuration to its defaults, the byte count, the found flag
// and both valid registers; the byte window holds no reset value.
// Top level of the wildcard byte pattern scanner; uses wbps_pkg, the channel
// interfaces, wbps_csr and wbps_match.
module wildcard_byte_pattern_scan (
   input  logic                              clock,
   input  logic                              reset,
   wbps_req_if.sink                          req,
   wbps_rsp_if.source                        rsp,
   input  logic                              csr_we,
   input  logic [wbps_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [wbps_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   wbps_pkg::cfg_type cfg;

   wbps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   wbps_match u_match (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

   // a beat never reports both a hit and a miss
   assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !(rsp.match_hit && rsp.no_match))
      else $error("hit and no-match in the same result beat");

   // the address is zero unless the beat is a hit
   assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.match_hit) |-> (rsp.match_address == '0))
      else $error("match address set without a hit");

   // no result beat comes out right after reset
   assert property (@(posedge clock)
      reset |=> !rsp.valid)
      else $error("result beat valid after reset");

endmodule
